// ----- rtl/hvc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heater temperature controller package
// Shared types, codes and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package hvc_pkg;

    // Item kinds carried on the input tuser bit.
    localparam logic KIND_TABLE_WRITE = 1'b0;
    localparam logic KIND_SAMPLE      = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SENSOR_MODE    = 3'd0;
    localparam logic [2:0] CFG_TARGET_TEMP    = 3'd1;
    localparam logic [2:0] CFG_DRIVE_HIGH     = 3'd2;
    localparam logic [2:0] CFG_DRIVE_LOW      = 3'd3;
    localparam logic [2:0] CFG_ENTRIES_IN_USE = 3'd4;

    // Sensor modes.
    localparam logic MODE_THERMISTOR   = 1'b0;
    localparam logic MODE_THERMOCOUPLE = 1'b1;

    // Heater levels.
    localparam logic [1:0] LVL_OFF  = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_HIGH = 2'd2;

    // Register reset values.
    localparam logic [8:0] RST_TARGET_TEMP    = 9'd0;
    localparam logic [7:0] RST_DRIVE_HIGH     = 8'd255;
    localparam logic [7:0] RST_DRIVE_LOW      = 8'd64;
    localparam logic [5:0] RST_ENTRIES_IN_USE = 6'd32;

    // Field widths.
    localparam int ADC_W     = 10;
    localparam int TEMP_W    = 11;
    localparam int SUM_W     = 16;
    localparam int ENTRIES_W = 6;
    localparam int INDEX_W   = 5;

    // Interpolation divider: 20-bit dividend, 10-bit divisor.
    localparam int DIV_DW  = 20;
    localparam int DIV_VW  = 10;
    localparam int DIV_CW  = 5;

    // Limit is floor(target * 11 / 10) = (target * 72094) >> 16 for targets below 512.
    localparam logic [16:0] LIMIT_MUL   = 17'd72094;
    localparam int          LIMIT_SHIFT = 16;

    // Thermocouple scale: avg * 500 >> 10.
    localparam logic [8:0] TC_MUL   = 9'd500;
    localparam int         TC_SHIFT = 10;

    // Which value is loaded into the temperature register.
    typedef enum logic [1:0] {
        TSEL_ZERO,
        TSEL_TC,
        TSEL_NODIV,
        TSEL_INTERP
    } t_temp_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      in_xfer;
        logic      avg_load;
        logic      walk_start;
        logic      walk_step;
        logic      interp_load;
        logic      interp_start;
        logic      temp_load;
        t_temp_sel temp_sel;
        logic      out_load;
    } t_hvc_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_sample;
        logic div_done;
        logic mode;
        logic hit;
        logic walk_last;
        logic den_zero;
        logic out_busy;
    } t_hvc_status;

endpackage
`default_nettype wire

// ----- rtl/hvc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, used by the interpolation
// step.
// ----------------------------------------------------------------------------
module hvc_div
    import hvc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_DW-1:0] i_dividend,
    input  wire logic [DIV_VW-1:0] i_divisor,
    output logic                   o_done,
    output logic [DIV_DW-1:0]      o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_VW-1:0] r_dvs;

    logic [DIV_VW:0]   trial;
    logic              ge;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        trial = {r_rem, r_quo[DIV_DW-1]};
        ge    = (trial >= {1'b0, r_dvs});
    end

    // Control state of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CW'(DIV_DW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - DIV_CW'(1);
            r_done <= (r_cnt == DIV_CW'(1));
            r_busy <= (r_cnt != DIV_CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_DW-2:0], ge};
            r_rem <= ge ? DIV_VW'(trial - {1'b0, r_dvs}) : trial[DIV_VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ----- rtl/hvc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heater temperature controller datapath
// Configuration registers, thermistor table memory, sample accumulator,
// interpolation arithmetic, heater decision and output register.
// ----------------------------------------------------------------------------
module hvc_datapath
    import hvc_pkg::*;
#(
    parameter int TABLE_ENTRIES       = 32,
    parameter int SAMPLES_PER_READING = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_hvc_cmd           i_cmd,
    output t_hvc_status             o_status,
    // Input item fields.
    input  wire logic               i_kind,
    input  wire logic [INDEX_W-1:0] i_entry_index,
    input  wire logic [ADC_W-1:0]   i_entry_raw,
    input  wire logic [ADC_W-1:0]   i_entry_celsius,
    input  wire logic [ADC_W-1:0]   i_adc_sample,
    // Configuration writes.
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [8:0]         i_cfg_data,
    // Result item.
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [TEMP_W-1:0]       o_temperature,
    output logic [7:0]              o_heater_duty,
    output logic [1:0]              o_heater_level
);

    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int CW  = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam int TNW = $clog2(TABLE_ENTRIES + 1);
    localparam int NW  = (TNW > ENTRIES_W) ? TNW : ENTRIES_W;

    // The average is sum * ceil(2^AVG_SH / N) >> AVG_SH, exact for sums below 2^SUM_W.
    localparam int AVG_L  = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 0;
    localparam int AVG_SH = SUM_W + AVG_L;
    localparam logic [SUM_W:0] AVG_MUL = (SUM_W+1)'(((64'd1 << AVG_SH)
        + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING));

    // Configuration registers.
    logic                 r_mode;
    logic [8:0]           r_target;
    logic [7:0]           r_drive_high;
    logic [7:0]           r_drive_low;
    logic [ENTRIES_W-1:0] r_entries;
    logic [9:0]           r_limit;

    // Table memory: celsius in the upper half, raw in the lower half.
    logic [2*ADC_W-1:0]   r_mem [TABLE_ENTRIES];
    logic [2*ADC_W-1:0]   r_rd;
    logic [2*ADC_W-1:0]   r_prev;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        rd_addr;
    logic                 wr_ok;
    logic [NW-1:0]        n_search;

    // Accumulator and arithmetic registers.
    logic [SUM_W-1:0]     r_sum;
    logic [CW-1:0]        r_count;
    logic [ADC_W-1:0]     r_avg;
    logic signed [21:0]   r_prod;
    logic signed [10:0]   r_den;
    logic [ADC_W-1:0]     r_c0;
    logic                 r_neg;
    logic [TEMP_W-1:0]    r_temp;

    // Output register.
    logic                 r_out_valid;
    logic [TEMP_W-1:0]    r_out_temp;
    logic [7:0]           r_out_duty;
    logic [1:0]           r_out_level;

    // Divider hookup.
    logic                 div_start;
    logic [DIV_DW-1:0]    div_dividend;
    logic [DIV_VW-1:0]    div_divisor;
    logic                 div_done;
    logic [DIV_DW-1:0]    div_quo;

    logic [2*SUM_W:0]     avg_prod;
    logic [ADC_W-1:0]     avg_w;
    logic signed [10:0]   diff_a;
    logic signed [10:0]   diff_c;
    logic signed [10:0]   den_w;
    logic signed [21:0]   prod_w;
    logic [21:0]          prod_mag;
    logic [10:0]          den_mag;
    logic signed [21:0]   quo_s;
    logic signed [21:0]   interp_sum;
    logic [18:0]          tc_prod;
    logic [8:0]           tc_val;
    logic [25:0]          lim_prod;
    logic [TEMP_W-1:0]    n_temp;
    logic signed [11:0]   temp_x;
    logic signed [11:0]   target_x;
    logic signed [11:0]   limit_x;

    // Clamp an interpolated value to the range -1024 to 255.
    function automatic logic [TEMP_W-1:0] sat_temp(input logic signed [21:0] v);
        logic [TEMP_W-1:0] res;
        if (v > 22'sd255) begin
            res = TEMP_W'(255);
        end else if (v < -22'sd1024) begin
            res = {1'b1, {(TEMP_W-1){1'b0}}};
        end else begin
            res = v[TEMP_W-1:0];
        end
        return res;
    endfunction

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_THERMISTOR;
            r_target     <= RST_TARGET_TEMP;
            r_drive_high <= RST_DRIVE_HIGH;
            r_drive_low  <= RST_DRIVE_LOW;
            r_entries    <= RST_ENTRIES_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SENSOR_MODE:    r_mode       <= i_cfg_data[0];
                CFG_TARGET_TEMP:    r_target     <= i_cfg_data;
                CFG_DRIVE_HIGH:     r_drive_high <= i_cfg_data[7:0];
                CFG_DRIVE_LOW:      r_drive_low  <= i_cfg_data[7:0];
                CFG_ENTRIES_IN_USE: r_entries    <= i_cfg_data[ENTRIES_W-1:0];
                default: ;
            endcase
        end
    end

    // The 1.1x limit is registered from the target and follows it in the next cycle.
    assign lim_prod = 26'(r_target) * 26'(LIMIT_MUL);
    always_ff @(posedge i_clk) begin
        r_limit <= lim_prod[LIMIT_SHIFT +: 10];
    end

    // Table writes and the walk read port.
    assign wr_ok    = (NW'(i_entry_index) < NW'(TABLE_ENTRIES));
    assign rd_addr  = i_cmd.walk_start ? '0 : r_idx + AW'(1);
    assign n_search = (NW'(r_entries) < NW'(TABLE_ENTRIES)) ? NW'(r_entries)
                                                            : NW'(TABLE_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_xfer && i_kind == KIND_TABLE_WRITE && wr_ok) begin
            r_mem[AW'(i_entry_index)] <= {i_entry_celsius, i_entry_raw};
        end
        if (i_cmd.walk_start || i_cmd.walk_step) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Walk position and the entry before the current one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_idx <= '0;
        end else if (i_cmd.walk_step) begin
            r_idx  <= r_idx + AW'(1);
            r_prev <= r_rd;
        end
    end

    // Sample accumulation; the sum is turned into the average and cleared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.in_xfer && i_kind == KIND_SAMPLE) begin
            r_sum   <= r_sum + SUM_W'(i_adc_sample);
            r_count <= o_status.last_sample ? '0 : r_count + CW'(1);
        end else if (i_cmd.avg_load) begin
            r_sum <= '0;
        end
    end

    // Average by reciprocal multiplication; it always fits the sample width.
    assign avg_prod = (2*SUM_W+1)'(r_sum) * (2*SUM_W+1)'(AVG_MUL);
    assign avg_w    = avg_prod[AVG_SH +: ADC_W];

    // Interpolation operands from the previous and current entries.
    always_comb begin
        diff_a   = $signed({1'b0, r_avg}) - $signed({1'b0, r_prev[ADC_W-1:0]});
        diff_c   = $signed({1'b0, r_rd[2*ADC_W-1:ADC_W]})
                 - $signed({1'b0, r_prev[2*ADC_W-1:ADC_W]});
        den_w    = $signed({1'b0, r_rd[ADC_W-1:0]}) - $signed({1'b0, r_prev[ADC_W-1:0]});
        prod_w   = diff_a * diff_c;
        prod_mag = r_prod[21] ? 22'(-r_prod) : 22'(r_prod);
        den_mag  = r_den[10] ? 11'(-r_den) : 11'(r_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.interp_load) begin
            r_prod <= prod_w;
            r_den  <= den_w;
            r_c0   <= r_prev[2*ADC_W-1:ADC_W];
        end
        if (i_cmd.interp_start) begin
            r_neg <= r_prod[21] ^ r_den[10];
        end
        if (i_cmd.avg_load) begin
            r_avg <= avg_w;
        end
    end

    // Divider operands: magnitudes of the interpolation product and span.
    assign div_start    = i_cmd.interp_start;
    assign div_dividend = prod_mag[DIV_DW-1:0];
    assign div_divisor  = den_mag[DIV_VW-1:0];

    hvc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Temperature candidates for each path.
    always_comb begin
        quo_s      = r_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
        interp_sum = $signed({12'b0, r_c0}) + quo_s;
        tc_prod    = 19'(r_avg) * 19'(TC_MUL);
        tc_val     = tc_prod[TC_SHIFT +: 9];
        case (i_cmd.temp_sel)
            TSEL_ZERO:   n_temp = '0;
            TSEL_TC:     n_temp = tc_val[8] ? TEMP_W'(255) : TEMP_W'(tc_val);
            TSEL_NODIV:  n_temp = sat_temp($signed({12'b0, r_c0}));
            TSEL_INTERP: n_temp = sat_temp(interp_sum);
            default:     n_temp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.temp_load) begin
            r_temp <= n_temp;
        end
    end

    // Heater decision and the output register.
    always_comb begin
        temp_x   = {r_temp[TEMP_W-1], r_temp};
        target_x = $signed({3'b000, r_target});
        limit_x  = $signed({2'b00, r_limit});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_temp <= r_temp;
            if (temp_x < target_x) begin
                r_out_duty  <= r_drive_high;
                r_out_level <= LVL_HIGH;
            end else if (temp_x < limit_x) begin
                r_out_duty  <= r_drive_low;
                r_out_level <= LVL_LOW;
            end else begin
                r_out_duty  <= '0;
                r_out_level <= LVL_OFF;
            end
        end
    end

    // Status back to the controller.
    always_comb begin
        o_status.last_sample = (i_kind == KIND_SAMPLE)
                            && (r_count == CW'(SAMPLES_PER_READING - 1));
        o_status.div_done    = div_done;
        o_status.mode        = r_mode;
        o_status.hit         = (r_idx != '0) && (r_rd[ADC_W-1:0] > r_avg);
        o_status.walk_last   = ((NW'(r_idx) + NW'(1)) >= n_search);
        o_status.den_zero    = (r_den == '0);
        o_status.out_busy    = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_temperature  = r_out_temp;
    assign o_heater_duty  = r_out_duty;
    assign o_heater_level = r_out_level;

endmodule
`default_nettype wire

// ----- rtl/hvc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heater temperature controller sequencer
// Accepts items, then steps the datapath through averaging, table walk and
// interpolation or thermocouple scaling, and the heater decision per reading.
// ----------------------------------------------------------------------------
module hvc_ctrl
    import hvc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_hvc_status i_status,
    output t_hvc_cmd         o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_MODE,
        ST_WALK,
        ST_INTERP_MUL,
        ST_INTERP_DIV,
        ST_INTERP_WAIT,
        ST_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.temp_sel = TSEL_ZERO;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.in_xfer = i_in_valid;
                if (i_in_valid && i_status.last_sample) begin
                    n_state = ST_AVG;
                end
            end
            ST_AVG: begin
                o_cmd.avg_load = 1'b1;
                n_state = ST_MODE;
            end
            ST_MODE: begin
                if (i_status.mode == MODE_THERMOCOUPLE) begin
                    o_cmd.temp_load = 1'b1;
                    o_cmd.temp_sel  = TSEL_TC;
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_status.hit) begin
                    n_state = ST_INTERP_MUL;
                end else if (i_status.walk_last) begin
                    o_cmd.temp_load = 1'b1;
                    o_cmd.temp_sel  = TSEL_ZERO;
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            ST_INTERP_MUL: begin
                o_cmd.interp_load = 1'b1;
                n_state = ST_INTERP_DIV;
            end
            ST_INTERP_DIV: begin
                if (i_status.den_zero) begin
                    o_cmd.temp_load = 1'b1;
                    o_cmd.temp_sel  = TSEL_NODIV;
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.interp_start = 1'b1;
                    n_state = ST_INTERP_WAIT;
                end
            end
            ST_INTERP_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.temp_load = 1'b1;
                    o_cmd.temp_sel  = TSEL_INTERP;
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/heater_temperature_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heater temperature controller
// Averages converter samples, converts the average to celsius by thermistor
// table interpolation or thermocouple scaling, and picks the heater drive.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tuser: kind; tdata: table entry or sample
// m_axis    out  m_axis_tvalid/tready      tdata: temperature, duty, level
// cfg       in   i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
// Table writes and samples that do not complete a reading are taken back to back.
// After the sample that completes a reading, the result appears and the input
// opens again after scaling in thermocouple mode, and in thermistor mode after
// a table walk at one entry per cycle through the memory read port and a
// one-bit-per-cycle division.
// Reset is synchronous and active low; table contents are not cleared.
// A stalled result waits in the output register while inputs are still taken;
// the next completed reading holds the input off until that register is free.
// ----------------------------------------------------------------------------
module heater_temperature_controller
    import hvc_pkg::*;
#(
    parameter int TABLE_ENTRIES       = 32,
    parameter int SAMPLES_PER_READING = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: entry_index[4:0], entry_raw[14:5], entry_celsius[24:15],
    //        adc_sample[34:25], zero[39:35]
    input  wire logic [39:0] s_axis_tdata,
    // tuser: kind (0: table write, 1: sample)
    input  wire logic        s_axis_tuser,
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: temperature[10:0], heater_duty[18:11], heater_level[20:19], zero[23:21]
    output logic [23:0]      m_axis_tdata,
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data
);

    t_hvc_cmd          cmd;
    t_hvc_status       status;
    logic [TEMP_W-1:0] temperature;
    logic [7:0]        heater_duty;
    logic [1:0]        heater_level;

    // Configuration is always taken.
    assign o_cfg_ready = 1'b1;

    hvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hvc_datapath #(
        .TABLE_ENTRIES       (TABLE_ENTRIES),
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_kind          (s_axis_tuser),
        .i_entry_index   (s_axis_tdata[4:0]),
        .i_entry_raw     (s_axis_tdata[14:5]),
        .i_entry_celsius (s_axis_tdata[24:15]),
        .i_adc_sample    (s_axis_tdata[34:25]),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_temperature   (temperature),
        .o_heater_duty   (heater_duty),
        .o_heater_level  (heater_level)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {3'b000, heater_level, heater_duty, temperature};

endmodule
`default_nettype wire
